/* rtl/rv32im_thread_execute_defines.svh */
// assertion macros shared by the execute unit files
`ifndef RV32IM_THREAD_EXECUTE_DEFINES_SVH
`define RV32IM_THREAD_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS
`define RTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RTE_ASSERT_NEVER(lbl, cond, msg) \
  `RTE_ASSERT(lbl, !(cond), msg)
`else
`define RTE_ASSERT(lbl, prop, msg)
`define RTE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/rte_pkg.sv */
// types and constants of the rv32im execute unit
package rte_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [3:0] ACT_NOP    = 4'd0;
  localparam logic [3:0] ACT_REG    = 4'd1;
  localparam logic [3:0] ACT_LOAD   = 4'd2;
  localparam logic [3:0] ACT_IMM    = 4'd3;
  localparam logic [3:0] ACT_STORE  = 4'd4;
  localparam logic [3:0] ACT_BRANCH = 4'd5;
  localparam logic [3:0] ACT_LUI    = 4'd6;
  localparam logic [3:0] ACT_AUIPC  = 4'd7;
  localparam logic [3:0] ACT_JAL    = 4'd8;
  localparam logic [3:0] ACT_JALR   = 4'd9;
  localparam logic [3:0] ACT_ID     = 4'd10;
  localparam logic [3:0] ACT_PJMP   = 4'd11;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;

  localparam logic [31:0] ID_THREAD = 32'h0000_0020;
  localparam logic [31:0] ID_WARP   = 32'h0000_0021;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         action;
    logic [2:0]         func3;
    logic [6:0]         func7;
    logic [31:0]        src_a;
    logic [31:0]        src_b;
    logic signed [31:0] immediate;
    logic [31:0]        instr_address;
    logic [31:0]        load_word;
    logic [4:0]         thread_index;
    logic [5:0]         warp_index;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_result;
    logic        pc_set;
    logic [31:0] next_pc;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic [2:0]  store_bytes;
    logic [1:0]  access;
    logic        illegal;
  } out_t;

  // queue head handed from front to back
  typedef struct packed {
    logic valid;
    logic md;
    in_t  item;
  } rte_op_t;

endpackage

/* rtl/rte_front.sv */
// front end: accepts words, marks multiply/divide, two-entry queue
`include "rv32im_thread_execute_defines.svh"
module rte_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rte_pkg::in_t    in_word_i,
  output rte_pkg::rte_op_t op_o,
  input  logic            pop_i
);
  import rte_pkg::*;

  rte_op_t    fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  rte_op_t    entry;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    entry       = '0;
    entry.valid = 1'b1;
    entry.item  = in_word_i;
    entry.md    = (in_word_i.action == ACT_REG) && in_word_i.func7[0];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= entry;
  end

  always_comb begin
    op_o       = fifo_q[rd_ptr_q];
    op_o.valid = (cnt_q != 2'd0);
  end

  `RTE_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `RTE_ASSERT(a_full_holds, (cnt_q == 2'd2 && !pop_i) |=> cnt_q == 2'd2, "full queue lost a word")
  `RTE_ASSERT_NEVER(a_pop_empty, pop_i && cnt_q == 2'd0, "pop from empty queue")

endmodule

/* rtl/rte_back.sv */
// back end: alu, load/store, branches, pipelined multiply and divide
`include "rv32im_thread_execute_defines.svh"
module rte_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rte_pkg::rte_op_t op_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rte_pkg::out_t    out_word_o
);
  import rte_pkg::*;

  typedef struct packed {
    out_t        res;
    logic        md;
    logic [2:0]  f3;
    logic        na;
    logic        nb;
    logic        bz;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] d;
  } stage_t;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] y;
    case (f3)
      F3_ADD:  y = alt ? a - b : a + b;
      F3_SLL:  y = a << b[4:0];
      F3_SLT:  y = {31'd0, ((a ^ SIGN_BIT) < (b ^ SIGN_BIT))};
      F3_SLTU: y = {31'd0, (a < b)};
      F3_XOR:  y = a ^ b;
      F3_SR:   y = alt ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   y = a | b;
      F3_AND:  y = a & b;
      default: y = '0;
    endcase
    return y;
  endfunction

  // one restoring division step, other words pass untouched
  function automatic stage_t div_step(input stage_t s);
    stage_t      o;
    logic [32:0] t, diff;
    o    = s;
    t    = {s.r, s.q[31]};
    diff = t - {1'b0, s.d};
    if (s.md && s.f3[2]) begin
      if (!diff[32]) begin
        o.r = diff[31:0];
        o.q = {s.q[30:0], 1'b1};
      end else begin
        o.r = t[31:0];
        o.q = {s.q[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] md_final(input stage_t s);
    logic [31:0] y;
    case (s.f3)
      F3_MUL:  y = s.q;
      F3_MULH, F3_MULHSU, F3_MULHU:
        y = s.r - (s.na ? s.b : 32'd0) - (s.nb ? s.a : 32'd0);
      F3_DIV:  y = s.bz ? '1 : ((s.na ^ s.nb) ? -s.q : s.q);
      F3_DIVU: y = s.q;
      F3_REM:  y = s.bz ? s.a : (s.na ? -s.r : s.r);
      F3_REMU: y = s.r;
      default: y = '0;
    endcase
    return y;
  endfunction

  stage_t st_q [DivSteps+1];
  logic   vld_q [DivSteps+1];
  stage_t s0;
  out_t   fin;
  logic   out_valid_q;
  out_t   out_q;
  logic   adv;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && op_i.valid;

  // first stage: everything but the multiply/divide result
  always_comb begin
    logic [31:0] a, b, imm, pc, lw, addr, v;
    logic [63:0] prod;
    logic        ill, take, sgn;
    a    = op_i.item.src_a;
    b    = op_i.item.src_b;
    imm  = op_i.item.immediate;
    pc   = op_i.item.instr_address;
    lw   = op_i.item.load_word;
    addr = a + imm;
    v    = lw >> {addr[1:0], 3'b000};
    ill  = 1'b0;
    take = 1'b0;
    prod = a * b;
    sgn  = ~op_i.item.func3[0];
    s0   = '0;
    s0.md = op_i.md;
    s0.f3 = op_i.item.func3;
    s0.a  = a;
    s0.b  = b;
    case (op_i.item.action)
      ACT_NOP: ;
      ACT_REG: begin
        s0.res.result       = alu(op_i.item.func3, op_i.item.func7 != 7'd0, a, b);
        s0.res.write_result = 1'b1;
      end
      ACT_LOAD: begin
        case (op_i.item.func3)
          F3_LB:   s0.res.result = {{24{v[7]}}, v[7:0]};
          F3_LH:   s0.res.result = {{16{v[15]}}, v[15:0]};
          F3_LW:   s0.res.result = lw;
          F3_LBU:  s0.res.result = {24'd0, v[7:0]};
          F3_LHU:  s0.res.result = {16'd0, v[15:0]};
          default: ill = 1'b1;
        endcase
        if (!ill) begin
          s0.res.write_result = 1'b1;
          s0.res.access       = ACC_LOAD;
          s0.res.mem_address  = addr & WORD_MASK;
        end else begin
          s0.res.result = '0;
        end
      end
      ACT_IMM: begin
        if (op_i.item.func3 == F3_SR) begin
          s0.res.result = alu(F3_SR, op_i.item.func7 != 7'd0, a, imm);
        end else begin
          s0.res.result = alu(op_i.item.func3, 1'b0, a, imm);
        end
        s0.res.write_result = 1'b1;
      end
      ACT_STORE: begin
        case (op_i.item.func3)
          F3_SB: begin
            s0.res.store_data  = {24'd0, b[7:0]};
            s0.res.store_bytes = 3'd1;
          end
          F3_SH: begin
            s0.res.store_data  = b;
            s0.res.store_bytes = 3'd2;
          end
          F3_SW: begin
            s0.res.store_data  = b;
            s0.res.store_bytes = 3'd4;
          end
          default: ill = 1'b1;
        endcase
        if (!ill) begin
          s0.res.mem_address = addr;
          s0.res.access      = ACC_STORE;
        end
      end
      ACT_BRANCH: begin
        case (op_i.item.func3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ((a ^ SIGN_BIT) < (b ^ SIGN_BIT));
          F3_BGE:  take = !((a ^ SIGN_BIT) < (b ^ SIGN_BIT));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: ill = 1'b1;
        endcase
        if (take) begin
          s0.res.pc_set  = 1'b1;
          s0.res.next_pc = pc + imm;
        end
      end
      ACT_LUI: begin
        s0.res.result       = imm << 12;
        s0.res.write_result = 1'b1;
      end
      ACT_AUIPC: begin
        s0.res.result       = (imm << 12) + pc;
        s0.res.write_result = 1'b1;
      end
      ACT_JAL: begin
        s0.res.pc_set       = 1'b1;
        s0.res.next_pc      = pc + imm;
        s0.res.result       = pc + 32'd4;
        s0.res.write_result = 1'b1;
      end
      ACT_JALR: begin
        s0.res.pc_set       = 1'b1;
        s0.res.next_pc      = {addr[31:1], 1'b0};
        s0.res.result       = pc + 32'd4;
        s0.res.write_result = 1'b1;
      end
      ACT_ID: begin
        if (imm == ID_THREAD) begin
          s0.res.result       = {27'd0, op_i.item.thread_index};
          s0.res.write_result = 1'b1;
        end else if (imm == ID_WARP) begin
          s0.res.result       = {26'd0, op_i.item.warp_index};
          s0.res.write_result = 1'b1;
        end
      end
      ACT_PJMP: begin
        if (a != 32'd0) begin
          s0.res.pc_set  = 1'b1;
          s0.res.next_pc = b;
        end
      end
      default: ill = 1'b1;
    endcase
    s0.res.illegal = ill;

    // multiply/divide operands
    if (op_i.item.func3[2]) begin
      s0.na = sgn && a[31];
      s0.nb = sgn && b[31];
      s0.bz = (b == 32'd0);
      s0.q  = s0.na ? -a : a;
      s0.d  = s0.nb ? -b : b;
      s0.r  = '0;
    end else begin
      s0.na = (op_i.item.func3 == F3_MULH || op_i.item.func3 == F3_MULHSU) && a[31];
      s0.nb = (op_i.item.func3 == F3_MULH) && b[31];
      s0.q  = prod[31:0];
      s0.r  = prod[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) st_q[0] <= s0;
  end

  for (genvar i = 1; i <= DivSteps; i++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) st_q[i] <= div_step(st_q[i-1]);
    end
  end

  always_comb begin
    fin = st_q[DivSteps].res;
    if (st_q[DivSteps].md) fin.result = md_final(st_q[DivSteps]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= fin;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `RTE_ASSERT(a_stall_keeps, (!adv && vld_q[DivSteps]) |=> vld_q[DivSteps], "stalled word lost")
  `RTE_ASSERT(a_first_moves, (adv && vld_q[0]) |=> vld_q[1], "word dropped in divide pipe")
  `RTE_ASSERT(a_pop_enters, pop_o |=> vld_q[0], "popped word not in first stage")

endmodule

/* rtl/rv32im_thread_execute.sv */
// top level of the rv32im per-thread execute unit
//
//  channel  | handshake               | word
//  ---------+-------------------------+--------------------------
//  in       | in_valid_i / in_ready_o | in_word_i  (rte_pkg::in_t)
//  out      | out_valid_o/ out_ready_i| out_word_o (rte_pkg::out_t)
//
// every word moves from the queue into the operand stage, through 32 restoring divide
// steps (one quotient bit each), and into the output register. one word per cycle in
// and out while the pipe advances; the pipe advances whenever the output register is
// empty or being taken, and a two-entry queue takes input meanwhile.
// reset clears the valid flags and the queue pointers and count; data registers are not reset.
module rv32im_thread_execute (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rte_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rte_pkg::out_t out_word_o
);
  import rte_pkg::*;

  rte_op_t op;
  logic    pop;

  rte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .op_o       (op),
    .pop_i      (pop)
  );

  rte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
